[rtl/barometric_pressure_compensation_top_macros.svh]
// Assertion macros for the pressure compensation block
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define BPC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bpc_pkg.sv]
// Shared types, constants and helpers of the pressure compensation block
`timescale 1ns / 1ps
package bpc_pkg;
	localparam int unsigned DIV_W = 32;

	localparam logic [2:0] REG_OSS     = 3'd0;
	localparam logic [2:0] REG_AC1_AC2 = 3'd1;
	localparam logic [2:0] REG_AC3_AC4 = 3'd2;
	localparam logic [2:0] REG_AC5_AC6 = 3'd3;
	localparam logic [2:0] REG_B1_B2   = 3'd4;
	localparam logic [2:0] REG_MC_MD   = 3'd5;

	localparam logic [31:0] C_B6_OFS  = 32'd4000;
	localparam logic [31:0] C_K3038   = 32'd3038;
	localparam logic [31:0] C_KM7357  = 32'hFFFF_E343;
	localparam logic [31:0] C_K3791   = 32'd3791;
	localparam logic [31:0] C_K50000  = 32'd50000;
	localparam logic [31:0] C_HALF    = 32'h8000_0000;
	localparam logic [31:0] C_K32768  = 32'd32768;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
		return $unsigned($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction
endpackage

[rtl/barometric_pressure_compensation_top.sv]
// Top level: sequencer around a shared multiplier and divider
//
// Usage: raw readings enter on in_valid/in_ready (raw_temp, raw_pressure);
// one result per transaction leaves on out_valid/out_ready (temp_tenths,
// pressure_pa, changed, div_error). Calibration and oversampling are written
// on cfg_valid/cfg_ready with cfg_index and cfg_data; the user must write
// calibration and oversampling only while idle, which the block does not
// enforce. cfg_ready is always high and unknown indexes are dropped. A full
// reading passes two waits on the shared divider and 19 other steps, 11 of
// which use the shared multiplier. A zero temperature divisor ends the reading
// at step T3, before the divider starts; a zero pressure divisor at step P10.
// in_ready is high only while the sequencer idles, so one reading is in
// work at a time. The finished result sits in an output register, so a new
// reading is taken while it waits; if the receiver still stalls when the
// next reading finishes, the sequencer holds until the register frees.
// A zero divisor gives zero results with div_error set and leaves the
// stored previous pair untouched. Reset clears the state, the configuration
// registers, the stored pair and the output valid, not the datapath registers.
`timescale 1ns / 1ps
`include "barometric_pressure_compensation_top_macros.svh"
module barometric_pressure_compensation_top import bpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        raw_temp,
	input  logic [23:0]        raw_pressure,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] temp_tenths,
	output logic [17:0]        pressure_pa,
	output logic               changed,
	output logic               div_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	typedef enum logic [21:0] {
		S_IDLE = 22'h000001, S_T1 = 22'h000002, S_T2 = 22'h000004,
		S_T3 = 22'h000008, S_TDIV = 22'h000010, S_P1 = 22'h000020,
		S_P2 = 22'h000040, S_P3 = 22'h000080, S_P4 = 22'h000100,
		S_P5 = 22'h000200, S_P6 = 22'h000400, S_P7 = 22'h000800,
		S_P8 = 22'h001000, S_P9 = 22'h002000, S_P10 = 22'h004000,
		S_P11 = 22'h008000, S_PDIV = 22'h010000, S_Q1 = 22'h020000,
		S_Q2 = 22'h040000, S_Q3 = 22'h080000, S_Q4 = 22'h100000,
		S_FIN = 22'h200000
	} state_t;

	state_t state_q;

	logic [1:0]  oss_q;
	logic [31:0] cal12_q, cal34_q, cal56_q, calb_q, calm_q;
	logic [15:0] last_t_q;
	logic [17:0] last_p_q;

	logic [31:0] ut_q, up_q;
	logic [31:0] x1_q, d_q, b5_q, b6_q, sq_q, x3_q, b3_q, b4_q, p_q;
	logic        neg_q, hi_q;

	logic [15:0] pend_t_q;
	logic [17:0] pend_p_q;
	logic        pend_err_q;

	logic        out_valid_q;
	logic [15:0] out_t_q;
	logic [17:0] out_p_q;
	logic        out_chg_q, out_err_q;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] mul_a, mul_b, prod;
	div_req_t    dreq;
	div_rsp_t    drsp;

	logic [31:0] nm, x2_t, b5_t, x3_t, b3_t, t_w, pr_w, x2_p;
	logic [15:0] t_sat;
	logic [17:0] p_sat;
	logic        in_fire, out_free;

	assign ac1 = sx16(cal12_q[31:16]);
	assign ac2 = sx16(cal12_q[15:0]);
	assign ac3 = sx16(cal34_q[31:16]);
	assign ac4 = {16'd0, cal34_q[15:0]};
	assign ac5 = {16'd0, cal56_q[31:16]};
	assign ac6 = {16'd0, cal56_q[15:0]};
	assign b1  = sx16(calb_q[31:16]);
	assign b2  = sx16(calb_q[15:0]);
	assign mc  = sx16(calm_q[31:16]);
	assign md  = sx16(calm_q[15:0]);

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	bpc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
	bpc_div #(.W(DIV_W)) u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// datapath values computed at single steps
	always_comb begin
		nm    = {mc[20:0], 11'd0};
		x2_t  = neg_q ? (32'd0 - drsp.quo) : drsp.quo;
		b5_t  = x1_q + x2_t;
		x3_t  = x1_q + asr(prod, 5'd11);
		b3_t  = asr((((ac1 << 2) + x3_t) << oss_q) + 32'd2, 5'd2);
		x2_p  = asr(prod, 5'd16);
		pr_w  = p_q + asr(x1_q + x2_p + C_K3791, 5'd4);
		t_w   = asr(b5_q + 32'd8, 5'd4);
		if ($signed(t_w) > 32'sd32767)       t_sat = 16'h7FFF;
		else if ($signed(t_w) < -32'sd32768) t_sat = 16'h8000;
		else                                 t_sat = t_w[15:0];
		if (pr_w[31])                        p_sat = 18'd0;
		else if (pr_w > 32'd262143)          p_sat = 18'h3FFFF;
		else                                 p_sat = pr_w[17:0];
	end

	// shared multiplier operands per step
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			S_T1:  begin mul_a = ut_q - ac6;          mul_b = ac5; end
			S_P1:  begin mul_a = b6_q;                mul_b = b6_q; end
			S_P3:  begin mul_a = b2;                  mul_b = sq_q; end
			S_P4:  begin mul_a = ac2;                 mul_b = b6_q; end
			S_P5:  begin mul_a = ac3;                 mul_b = b6_q; end
			S_P6:  begin mul_a = b1;                  mul_b = sq_q; end
			S_P8:  begin mul_a = ac4;                 mul_b = x3_q + C_K32768; end
			S_P10: begin mul_a = up_q - b3_q;         mul_b = C_K50000 >> oss_q; end
			S_Q1:  begin mul_a = asr(p_q, 5'd8);      mul_b = asr(p_q, 5'd8); end
			S_Q2:  begin mul_a = prod;                mul_b = C_K3038; end
			S_Q3:  begin mul_a = C_KM7357;            mul_b = p_q; end
			default: begin mul_a = 32'd0;             mul_b = 32'd0; end
		endcase
	end

	// divider requests: temperature step and pressure step
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = 32'd0;
		dreq.den   = 32'd0;
		case (state_q)
			S_T3: begin
				dreq.start = (d_q != 32'd0);
				dreq.num   = abs32(nm);
				dreq.den   = abs32(d_q);
			end
			S_P11: begin
				dreq.start = 1'b1;
				dreq.num   = (prod < C_HALF) ? (prod << 1) : prod;
				dreq.den   = b4_q;
			end
			default: dreq.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q   <= 2'd0;
			cal12_q <= 32'd0;
			cal34_q <= 32'd0;
			cal56_q <= 32'd0;
			calb_q  <= 32'd0;
			calm_q  <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OSS:     oss_q   <= cfg_data[1:0];
				REG_AC1_AC2: cal12_q <= cfg_data;
				REG_AC3_AC4: cal34_q <= cfg_data;
				REG_AC5_AC6: cal56_q <= cfg_data;
				REG_B1_B2:   calb_q  <= cfg_data;
				REG_MC_MD:   calm_q  <= cfg_data;
				default:     oss_q   <= oss_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			last_t_q    <= 16'd0;
			last_p_q    <= 18'd0;
		end else begin
			// a result leaving while the next one loads keeps valid high
			if (out_valid_q && out_ready && !(state_q == S_FIN))
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (in_fire) state_q <= S_T1;
				S_T1:    state_q <= S_T2;
				S_T2:    state_q <= S_T3;
				S_T3:    state_q <= (d_q == 32'd0) ? S_FIN : S_TDIV;
				S_TDIV:  if (drsp.done) state_q <= S_P1;
				S_P1:    state_q <= S_P2;
				S_P2:    state_q <= S_P3;
				S_P3:    state_q <= S_P4;
				S_P4:    state_q <= S_P5;
				S_P5:    state_q <= S_P6;
				S_P6:    state_q <= S_P7;
				S_P7:    state_q <= S_P8;
				S_P8:    state_q <= S_P9;
				S_P9:    state_q <= S_P10;
				S_P10:   state_q <= (b4_q == 32'd0) ? S_FIN : S_P11;
				S_P11:   state_q <= S_PDIV;
				S_PDIV:  if (drsp.done) state_q <= S_Q1;
				S_Q1:    state_q <= S_Q2;
				S_Q2:    state_q <= S_Q3;
				S_Q3:    state_q <= S_Q4;
				S_Q4:    state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (!pend_err_q) begin
							last_t_q <= pend_t_q;
							last_p_q <= pend_p_q;
						end
						state_q <= S_IDLE;
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					ut_q <= {16'd0, raw_temp};
					up_q <= {8'd0, raw_pressure >> (4'd8 - {2'd0, oss_q})};
				end
			end
			S_T2: begin
				x1_q <= asr(prod, 5'd15);
				d_q  <= asr(prod, 5'd15) + md;
			end
			S_T3: begin
				neg_q <= nm[31] ^ d_q[31];
				if (d_q == 32'd0) begin
					pend_err_q <= 1'b1;
					pend_t_q   <= 16'd0;
					pend_p_q   <= 18'd0;
				end
			end
			S_TDIV: begin
				if (drsp.done) begin
					b5_q <= b5_t;
					b6_q <= b5_t - C_B6_OFS;
				end
			end
			S_P2:  sq_q <= asr(prod, 5'd12);
			S_P4:  x1_q <= asr(prod, 5'd11);
			S_P5:  b3_q <= b3_t;
			S_P6:  x1_q <= asr(prod, 5'd13);
			S_P7:  x3_q <= asr(x1_q + asr(prod, 5'd16) + 32'd2, 5'd2);
			S_P9:  b4_q <= prod >> 15;
			S_P10: begin
				if (b4_q == 32'd0) begin
					pend_err_q <= 1'b1;
					pend_t_q   <= 16'd0;
					pend_p_q   <= 18'd0;
				end
			end
			S_P11: hi_q <= !(prod < C_HALF);
			S_PDIV: begin
				if (drsp.done)
					p_q <= hi_q ? (drsp.quo << 1) : drsp.quo;
			end
			S_Q3: x1_q <= asr(prod, 5'd16);
			S_Q4: begin
				pend_err_q <= 1'b0;
				pend_t_q   <= t_sat;
				pend_p_q   <= p_sat;
			end
			S_FIN: begin
				if (out_free) begin
					out_t_q   <= pend_t_q;
					out_p_q   <= pend_p_q;
					out_err_q <= pend_err_q;
					out_chg_q <= !pend_err_q &&
						((pend_t_q != last_t_q) || (pend_p_q != last_p_q));
				end
			end
			default: ut_q <= ut_q;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign temp_tenths = $signed(out_t_q);
	assign pressure_pa = out_p_q;
	assign changed     = out_chg_q;
	assign div_error   = out_err_q;

	`BPC_ASSERT(a_err_zero, out_valid && div_error, (temp_tenths == 16'sd0) && (pressure_pa == 18'd0), "error result not zero")
	`BPC_ASSERT(a_err_nochg, out_valid && div_error, !changed, "changed set on error result")
	`BPC_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready while reading in work")
	`BPC_ASSERT(a_div_idle, state_q == S_IDLE, !drsp.done, "divider finished while idle")
endmodule

[rtl/bpc_mul.sv]
// Shared 32x32 multiplier, low word of the product, registered
`timescale 1ns / 1ps
module bpc_mul import bpc_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] prod
);
	logic [31:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;
endmodule

[rtl/bpc_div.sv]
// Iterative restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bpc_div import bpc_pkg::*; #(
	parameter int unsigned W = DIV_W
) (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    rem_sh;
	logic [W:0]    rem_sub;

	assign rem_sh  = {rem_q[W-1:0], quo_q[W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num[W-1:0];
			den_q <= req.den[W-1:0];
		end else if (busy_q) begin
			if (!rem_sub[W]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = 32'(quo_q);
endmodule
